>>> hw/rtl/rrts_pkg.sv
// Shared types and constants of the round-robin thread scheduler.
// Used by the channel interfaces and by round_robin_thread_scheduler_top.
package rrts_pkg;

  // Field widths of the command and result transactions
  localparam int CMD_W      = 3;
  localparam int CHAN_W     = 2;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int THR_W      = 3;
  localparam int LIVE_W     = 4;

  // Default sizing
  localparam int THREADS_DEF  = 8;
  localparam int CHANNELS_DEF = 4;

  // Per-slot thread state
  typedef enum logic [1:0] {
    TS_FREE    = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_BLOCKED = 2'd3
  } thr_state_t;

  // Commands issued by the current thread (codes 5 to 7 are ignored)
  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN = 3'd0,
    CMD_YIELD = 3'd1,
    CMD_EXIT  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 3'd0,
    RS_NOSLOT   = 3'd1,
    RS_DEADLOCK = 3'd2,
    RS_MAINEXIT = 3'd3,
    RS_BLOCKED  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } seq_state_t;

endpackage

>>> hw/rtl/rrts_cmd_if.sv
// Command channel of the thread scheduler: valid/ready plus command payload.
// Depends on rrts_pkg for field widths.
interface rrts_cmd_if;
  import rrts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [CHAN_W-1:0]        channel;
  logic signed [DATA_W-1:0] send_value;

  modport source (output valid, output command, output channel, output send_value,
                  input ready);
  modport sink   (input valid, input command, input channel, input send_value,
                  output ready);
endinterface

>>> hw/rtl/rrts_res_if.sv
// Result channel of the thread scheduler: valid/ready plus result payload.
// Depends on rrts_pkg for field widths.
interface rrts_res_if;
  import rrts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [THR_W-1:0]         running_thread;
  logic [THR_W-1:0]         spawned_slot;
  logic signed [DATA_W-1:0] received_value;
  logic [LIVE_W-1:0]        live_threads;

  modport source (output valid, output status, output running_thread,
                  output spawned_slot, output received_value, output live_threads,
                  input ready);
  modport sink   (input valid, input status, input running_thread,
                  input spawned_slot, input received_value, input live_threads,
                  output ready);
endinterface

>>> hw/rtl/round_robin_thread_scheduler_top.sv
// Round-robin cooperative thread scheduler with single-entry channels.
// Depends on rrts_pkg, rrts_cmd_if and rrts_res_if.
//
//   port  dir  transaction  payload
//   cmd   in   command      command[2:0], channel[1:0], send_value[31:0]
//   res   out  result       status, running_thread, spawned_slot,
//                           received_value, live_threads
//
// Sequencing: one command at a time. Exit by thread 0, receive from a full channel and
// unknown codes go through accept, execute and finish; spawn, yield, exit, send and
// a blocking receive add a scan between execute and finish that checks one thread
// slot per cycle through a single state comparator.
// Reset: synchronous on rst; slot 0 running, all others free, channels empty.
// Stalls: a finished result sits in the output register until taken; a new command
// is accepted meanwhile, and its result waits in the finish state if needed.
module round_robin_thread_scheduler_top #(
  parameter int THREADS  = rrts_pkg::THREADS_DEF,
  parameter int CHANNELS = rrts_pkg::CHANNELS_DEF
) (
  input logic      clk,
  input logic      rst,
  rrts_cmd_if.sink   cmd,
  rrts_res_if.source res
);
  import rrts_pkg::*;

  localparam int TW = $clog2(THREADS);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW = $clog2(THREADS + 1);

  // Channel index wraps modulo CHANNELS (input is at most 3)
  function automatic logic [CW-1:0] ch_wrap(input logic [CHAN_W-1:0] c);
    logic [CHAN_W:0] v;
    v = {1'b0, c};
    for (int k = 0; k < 3; k++) begin
      if (int'(v) >= CHANNELS) v = v - (CHAN_W+1)'(CHANNELS);
    end
    return CW'(v);
  endfunction

  // Next slot in round-robin order
  function automatic logic [TW-1:0] slot_inc(input logic [TW-1:0] s);
    return (s == TW'(THREADS - 1)) ? '0 : s + TW'(1);
  endfunction

  seq_state_t state, state_next;

  // Scheduler state
  thr_state_t          thr_state [THREADS];
  logic [TW-1:0]       cur;
  logic [LW-1:0]       live;
  logic [CHANNELS-1:0] chan_full;
  logic [CHANNELS-1:0] rdr_vld;
  logic [CHANNELS-1:0] wtr_vld;

  // Channel memories, read at accept, written during execute
  logic signed [DATA_W-1:0] chan_val_mem [CHANNELS];
  logic [TW-1:0]            rdr_mem [CHANNELS];
  logic [TW-1:0]            wtr_mem [CHANNELS];
  logic signed [DATA_W-1:0] val_rd;
  logic [TW-1:0]            rdr_rd;
  logic [TW-1:0]            wtr_rd;

  // Latched command
  logic [CMD_W-1:0]         cmd_q;
  logic [CW-1:0]            ch_q;
  logic signed [DATA_W-1:0] val_q;

  // Scan sequencer
  logic [TW-1:0] idx;
  logic [TW-1:0] cnt;
  logic          scan_spawn;
  logic          blk;

  // Pending result
  status_t                  res_status;
  logic [TW-1:0]            res_spawn;
  logic signed [DATA_W-1:0] res_recv;

  // Output register
  logic                     out_vld;
  status_t                  out_status;
  logic [THR_W-1:0]         out_running;
  logic [THR_W-1:0]         out_spawned;
  logic signed [DATA_W-1:0] out_received;
  logic [LIVE_W-1:0]        out_live;

  logic          accept;
  logic          out_load;
  logic          exec_scan;
  logic          scan_hit;
  logic          scan_last;
  thr_state_t    scan_target;
  logic [CW-1:0] ch_in;
  logic          wr_val_en;
  logic          wr_rdr_en;
  logic          wr_wtr_en;

  assign ch_in  = ch_wrap(cmd.channel);
  assign accept = cmd.valid && cmd.ready;

  // Shared scan comparator: one slot per cycle
  assign scan_target = scan_spawn ? TS_FREE : TS_READY;
  assign scan_hit    = (thr_state[idx] == scan_target);
  assign scan_last   = (cnt == TW'(THREADS - 1));

  // Channel memory write strobes
  assign wr_val_en = (state == S_EXEC) && (cmd_q == CMD_SEND) && !chan_full[ch_q];
  assign wr_wtr_en = (state == S_EXEC) && (cmd_q == CMD_SEND) && chan_full[ch_q];
  assign wr_rdr_en = (state == S_EXEC) && (cmd_q == CMD_RECV) && !chan_full[ch_q];

  // Does the executed command continue with a scan
  always_comb begin
    unique case (cmd_q)
      CMD_SPAWN, CMD_YIELD, CMD_SEND: exec_scan = 1'b1;
      CMD_EXIT:                       exec_scan = (cur != '0);
      CMD_RECV:                       exec_scan = !chan_full[ch_q];
      default:                        exec_scan = 1'b0;
    endcase
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = exec_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (scan_hit || scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        out_load = !out_vld || res.ready;
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Channel memories
  always_ff @(posedge clk) begin
    if (accept) begin
      val_rd <= chan_val_mem[ch_in];
      rdr_rd <= rdr_mem[ch_in];
      wtr_rd <= wtr_mem[ch_in];
    end
    if (wr_val_en) chan_val_mem[ch_q] <= val_q;
    if (wr_wtr_en) wtr_mem[ch_q] <= cur;
    if (wr_rdr_en) rdr_mem[ch_q] <= cur;
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd.command;
      ch_q  <= ch_in;
      val_q <= cmd.send_value;
    end
  end

  // Execute and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) thr_state[t] <= TS_FREE;
      thr_state[0] <= TS_RUNNING;
      cur        <= '0;
      live       <= LW'(1);
      chan_full  <= '0;
      rdr_vld    <= '0;
      wtr_vld    <= '0;
      idx        <= '0;
      cnt        <= '0;
      scan_spawn <= 1'b0;
      blk        <= 1'b0;
    end else begin
      unique case (state)
        S_EXEC: begin
          res_status <= RS_OK;
          res_spawn  <= '0;
          res_recv   <= '0;
          blk        <= 1'b0;
          cnt        <= '0;
          scan_spawn <= 1'b0;
          idx        <= slot_inc(cur);
          unique case (cmd_q)
            CMD_SPAWN: begin
              scan_spawn <= 1'b1;
              idx        <= '0;
            end
            CMD_EXIT: begin
              if (cur == '0) begin
                res_status <= RS_MAINEXIT;
              end else if (thr_state[cur] != TS_FREE) begin
                thr_state[cur] <= TS_FREE;
                live           <= live - LW'(1);
              end
            end
            CMD_SEND: begin
              if (chan_full[ch_q]) begin
                thr_state[cur]   <= TS_BLOCKED;
                wtr_vld[ch_q]    <= 1'b1;
                blk              <= 1'b1;
              end else begin
                chan_full[ch_q] <= 1'b1;
                if (rdr_vld[ch_q]) begin
                  thr_state[rdr_rd] <= TS_READY;
                  rdr_vld[ch_q]     <= 1'b0;
                end
              end
            end
            CMD_RECV: begin
              if (!chan_full[ch_q]) begin
                thr_state[cur] <= TS_BLOCKED;
                rdr_vld[ch_q]  <= 1'b1;
                blk            <= 1'b1;
              end else begin
                res_recv        <= val_rd;
                chan_full[ch_q] <= 1'b0;
                if (wtr_vld[ch_q]) begin
                  thr_state[wtr_rd] <= TS_READY;
                  wtr_vld[ch_q]     <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_hit) begin
            if (scan_spawn) begin
              // lowest free slot found
              thr_state[idx] <= TS_READY;
              live           <= live + LW'(1);
              res_spawn      <= idx;
              res_status     <= RS_OK;
            end else begin
              // switch to the ready slot; same slot as cur ends up running
              if (thr_state[cur] == TS_RUNNING) thr_state[cur] <= TS_READY;
              thr_state[idx] <= TS_RUNNING;
              cur            <= idx;
              res_status     <= blk ? RS_BLOCKED : RS_OK;
            end
          end else if (scan_last) begin
            if (scan_spawn)                       res_status <= RS_NOSLOT;
            else if (thr_state[cur] == TS_RUNNING) res_status <= blk ? RS_BLOCKED : RS_OK;
            else                                  res_status <= RS_DEADLOCK;
          end else begin
            idx <= slot_inc(idx);
            cnt <= cnt + TW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)           out_vld <= 1'b0;
    else if (out_load) out_vld <= 1'b1;
    else if (res.ready) out_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status   <= res_status;
      out_running  <= THR_W'(cur);
      out_spawned  <= THR_W'(res_spawn);
      out_received <= res_recv;
      out_live     <= LIVE_W'(live);
    end
  end

  assign res.valid          = out_vld;
  assign res.status         = out_status;
  assign res.running_thread = out_running;
  assign res.spawned_slot   = out_spawned;
  assign res.received_value = out_received;
  assign res.live_threads   = out_live;

  // Checks
  // A waiter slot that exited can be woken later, so the live count is only
  // held steady outside execute and scan, not tied to the occupied slots.
  a_live_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |=> $stable(live))
    else $error("live count changed outside execute and scan");

  a_main_alive: assert property (@(posedge clk) disable iff (rst)
    thr_state[0] != TS_FREE)
    else $error("thread 0 slot was freed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("command accepted while previous one is in progress");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state == S_FINISH))
    else $error("result register loaded outside finish state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_hit && scan_last) |=> (state == S_FINISH))
    else $error("scan ran past the last slot");

endmodule

>>> tb/round_robin_thread_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_thread_scheduler_top: directed table then random
// commands, checked against a behavioral scheduler model. Needs rrts_pkg and the cmd/res ifs.
module round_robin_thread_scheduler_top_tb;
  import rrts_pkg::*;

  localparam int NTHR        = THREADS_DEF;
  localparam int NCHAN       = CHANNELS_DEF;
  localparam int RANDOM_CMDS = 1024;
  localparam int DRAIN_CYCLES = 2 * (NTHR + 3);
  localparam int CYCLE_LIMIT = 400000;

  // Reserved command codes, ignored by the scheduler
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct packed {
    status_t                   status;
    logic [THR_W-1:0]          running_thread;
    logic [THR_W-1:0]          spawned_slot;
    logic [DATA_W-1:0]         received_value;
    logic [LIVE_W-1:0]         live_threads;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]  code;
    logic [CHAN_W-1:0] ch;
    logic [DATA_W-1:0] val;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrts_cmd_if cmd_if ();
  rrts_res_if res_if ();

  round_robin_thread_scheduler_top uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  always #6 clk = ~clk;

  // Scheduler model state
  thr_state_t        slot_st     [NTHR];
  logic [THR_W-1:0]  cur_slot;
  logic [LIVE_W-1:0] live_cnt;
  logic [DATA_W-1:0] mbox_data   [NCHAN];
  bit                mbox_full   [NCHAN];
  bit                rd_waiting  [NCHAN];
  logic [THR_W-1:0]  rd_slot     [NCHAN];
  bit                wr_waiting  [NCHAN];
  logic [THR_W-1:0]  wr_slot     [NCHAN];

  result_t     expected_results [$];
  stim_row_t   directed_rows [$];
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  int unsigned mix_mode = 0;
  int unsigned stall_mode = 0;
  logic [31:0] rx_cycle = '0;

  task automatic sched_reset();
    for (int i = 0; i < NTHR; i++) slot_st[i] = TS_FREE;
    slot_st[0] = TS_RUNNING;
    cur_slot = '0;
    live_cnt = 4'd1;
    for (int c = 0; c < NCHAN; c++) begin
      mbox_data[c]  = '0;
      mbox_full[c]  = 1'b0;
      rd_waiting[c] = 1'b0;
      rd_slot[c]    = '0;
      wr_waiting[c] = 1'b0;
      wr_slot[c]    = '0;
    end
  endtask

  // Round-robin hand-off: scan after the current slot, current slot last
  function automatic status_t switch_thread();
    logic [THR_W-1:0] idx;
    for (int i = 1; i <= NTHR; i++) begin
      idx = cur_slot + THR_W'(i);
      if (slot_st[idx] == TS_READY) begin
        if (slot_st[cur_slot] == TS_RUNNING) slot_st[cur_slot] = TS_READY;
        cur_slot = idx;
        slot_st[idx] = TS_RUNNING;
        return RS_OK;
      end
    end
    if (slot_st[cur_slot] == TS_RUNNING) return RS_OK;
    return RS_DEADLOCK;
  endfunction

  // Apply one command to the model and return the result it produces
  function automatic result_t predict_command(input logic [CMD_W-1:0] code,
                                              input logic [CHAN_W-1:0] ch,
                                              input logic [DATA_W-1:0] val);
    result_t          r;
    logic [THR_W-1:0] me;
    int               c;
    r = '0;
    r.status = RS_OK;
    me = cur_slot;
    c = int'(ch) % NCHAN;
    case (code)
      CMD_SPAWN: begin
        r.status = RS_NOSLOT;
        for (int i = 0; i < NTHR; i++) begin
          if (r.status == RS_NOSLOT && slot_st[i] == TS_FREE) begin
            slot_st[i] = TS_READY;
            live_cnt = live_cnt + 1'b1;
            r.spawned_slot = THR_W'(i);
            r.status = RS_OK;
          end
        end
      end
      CMD_YIELD: r.status = switch_thread();
      CMD_EXIT: begin
        if (me == '0) begin
          r.status = RS_MAINEXIT;
        end else begin
          // a slot freed earlier is not counted down twice
          if (slot_st[me] != TS_FREE) begin
            slot_st[me] = TS_FREE;
            live_cnt = live_cnt - 1'b1;
          end
          r.status = switch_thread();
        end
      end
      CMD_SEND: begin
        if (mbox_full[c]) begin
          slot_st[me] = TS_BLOCKED;
          wr_waiting[c] = 1'b1;
          wr_slot[c] = me;
          r.status = switch_thread();
          if (r.status == RS_OK) r.status = RS_BLOCKED;
        end else begin
          mbox_data[c] = val;
          mbox_full[c] = 1'b1;
          if (rd_waiting[c]) begin
            slot_st[rd_slot[c]] = TS_READY;
            rd_waiting[c] = 1'b0;
          end
          r.status = switch_thread();
        end
      end
      CMD_RECV: begin
        if (!mbox_full[c]) begin
          slot_st[me] = TS_BLOCKED;
          rd_waiting[c] = 1'b1;
          rd_slot[c] = me;
          r.status = switch_thread();
          if (r.status == RS_OK) r.status = RS_BLOCKED;
        end else begin
          r.received_value = mbox_data[c];
          mbox_full[c] = 1'b0;
          if (wr_waiting[c]) begin
            slot_st[wr_slot[c]] = TS_READY;
            wr_waiting[c] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.running_thread = cur_slot;
    r.live_threads = live_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, what);
    error_count++;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] code, input logic [CHAN_W-1:0] ch,
                         input logic [DATA_W-1:0] val);
    stim_row_t row;
    row.code = code;
    row.ch = ch;
    row.val = val;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [CMD_W-1:0] code, input logic [CHAN_W-1:0] ch,
                           input logic [DATA_W-1:0] val, input status_t st,
                           input logic [THR_W-1:0] run, input logic [THR_W-1:0] slot,
                           input logic [DATA_W-1:0] rcv, input logic [LIVE_W-1:0] live);
    stim_row_t row;
    row.code = code;
    row.ch = ch;
    row.val = val;
    row.typed = 1'b1;
    row.want.status = st;
    row.want.running_thread = run;
    row.want.spawned_slot = slot;
    row.want.received_value = rcv;
    row.want.live_threads = live;
    directed_rows.push_back(row);
  endtask

  // Drive one command transaction, hold it until accepted, then log its expected result
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [CHAN_W-1:0] ch,
                              input logic [DATA_W-1:0] val, input bit typed,
                              input result_t want);
    result_t predicted;
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= code;
    cmd_if.channel    <= ch;
    cmd_if.send_value <= val;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = predict_command(code, ch, val);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Command mix shifts between balanced, channel-heavy and exit-heavy phases
  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    int unsigned w_spawn, w_yield, w_exit, w_send;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_RSVD_FIRST + CMD_W'($urandom_range(0, 2));
    case (mix_mode)
      0:       begin w_spawn = 15; w_yield = 20; w_exit = 15; w_send = 25; end
      1:       begin w_spawn = 25; w_yield = 15; w_exit = 5;  w_send = 28; end
      default: begin w_spawn = 10; w_yield = 15; w_exit = 35; w_send = 20; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_spawn) return CMD_SPAWN;
    if (roll < w_spawn + w_yield) return CMD_YIELD;
    if (roll < w_spawn + w_yield + w_exit) return CMD_EXIT;
    if (roll < w_spawn + w_yield + w_exit + w_send) return CMD_SEND;
    return CMD_RECV;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transaction with nothing pending");
    end else begin
      want = expected_results.pop_front();
      if (res_if.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", res_if.status, want.status));
      if (res_if.running_thread !== want.running_thread)
        report_mismatch($sformatf("running_thread %0d, want %0d",
                                  res_if.running_thread, want.running_thread));
      if (res_if.spawned_slot !== want.spawned_slot)
        report_mismatch($sformatf("spawned_slot %0d, want %0d",
                                  res_if.spawned_slot, want.spawned_slot));
      if (res_if.received_value !== want.received_value)
        report_mismatch($sformatf("received_value %h, want %h",
                                  res_if.received_value, want.received_value));
      if (res_if.live_threads !== want.live_threads)
        report_mismatch($sformatf("live_threads %0d, want %0d",
                                  res_if.live_threads, want.live_threads));
    end
    result_count++;
  endtask

  // Result side: check accepted transactions, stall on a shifting pattern
  always @(posedge clk) begin : rx_side
    bit take;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      rx_cycle = rx_cycle + 1;
      if (rx_cycle[6:0] == '0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 3) != 0);
        2:       take = ((rx_cycle % 5) < 2);
        default: take = rx_cycle[4];
      endcase
      res_if.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned burst_left;
    result_t     no_want;
    no_want = '0;
    burst_left = 0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_YIELD;
    cmd_if.channel    = '0;
    cmd_if.send_value = '0;
    sched_reset();

    // Directed walk: main-exit refusal, deadlocks, exit of a freed slot,
    // blocking on both channel ends, wake-ups, full slot table, ignored codes
    add_typed(CMD_YIELD, 2'd0, 32'h0, RS_OK, 3'd0, 3'd0, 32'h0, 4'd1);
    add_typed(CMD_EXIT,  2'd0, 32'h0, RS_MAINEXIT, 3'd0, 3'd0, 32'h0, 4'd1);
    add_typed(CMD_SPAWN, 2'd0, 32'h0, RS_OK, 3'd0, 3'd1, 32'h0, 4'd2);
    add_row(CMD_RECV, 2'd0, 32'h0);
    add_typed(CMD_EXIT,  2'd0, 32'h0, RS_DEADLOCK, 3'd1, 3'd0, 32'h0, 4'd1);
    add_typed(CMD_EXIT,  2'd0, 32'h0, RS_DEADLOCK, 3'd1, 3'd0, 32'h0, 4'd1);
    add_row(CMD_SEND, 2'd0, 32'h7FFF_FFFF);
    add_row(CMD_RECV, 2'd0, 32'h0);
    add_typed(CMD_RECV,  2'd1, 32'h0, RS_DEADLOCK, 3'd0, 3'd0, 32'h0, 4'd1);
    add_typed(CMD_SPAWN, 2'd0, 32'h0, RS_OK, 3'd0, 3'd1, 32'h0, 4'd2);
    add_row(CMD_SEND, 2'd1, 32'h8000_0000);
    add_row(CMD_SEND, 2'd1, 32'h0000_0000);
    add_row(CMD_RECV, 2'd1, 32'h0);
    for (int i = 0; i < NTHR - 2; i++) add_row(CMD_SPAWN, 2'd0, 32'h0);
    add_typed(CMD_SPAWN,      2'd0, 32'h0, RS_NOSLOT, 3'd0, 3'd0, 32'h0, 4'd8);
    add_typed(CMD_RSVD_FIRST, 2'd3, 32'hFFFF_FFFF, RS_OK, 3'd0, 3'd0, 32'h0, 4'd8);
    add_typed(CMD_RSVD_MID,   2'd2, 32'h0, RS_OK, 3'd0, 3'd0, 32'h0, 4'd8);
    add_typed(CMD_RSVD_LAST,  2'd1, 32'h0, RS_OK, 3'd0, 3'd0, 32'h0, 4'd8);
    add_row(CMD_SEND, 2'd3, 32'hFFFF_FFFF);
    add_row(CMD_YIELD, 2'd0, 32'h0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].code, directed_rows[i].ch, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);
      pause_sender($urandom_range(0, 3));
    end

    // Random commands in bursts; long bursts give stretches with no sender idling
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 48 == 0) mix_mode = $urandom_range(0, 2);
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
        pause_sender($urandom_range(1, 10));
      end
      send_command(pick_command(), CHAN_W'($urandom_range(0, NCHAN - 1)), pick_value(),
                   1'b0, no_want);
      burst_left--;
    end
    cmd_if.valid <= 1'b0;

    // Drain outstanding results, then watch for stray transactions
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
